// ----- src/rate_monotonic_ready_queue_core_assert.svh -----
// assertion macros for the ready queue core
`ifndef RATE_MONOTONIC_READY_QUEUE_CORE_ASSERT_SVH
`define RATE_MONOTONIC_READY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define RMRQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define RMRQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RMRQ_ASSERT(label, clk, rst, prop, msg)
`define RMRQ_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- src/rmrq_pkg.sv -----
package rmrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_QUEUED   = 3'd0;
   localparam logic [2:0] ST_PREEMPT  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_IDLE     = 3'd4;
   localparam logic [2:0] ST_RAN      = 3'd5;

   localparam logic CMD_RELEASE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef struct packed {
      logic [15:0] period;
      logic [15:0] cost;
      logic [15:0] remaining;
      logic [7:0]  task_id;
      logic [31:0] release_time;
      logic [15:0] tag;
   } slot_type;

   typedef struct packed {
      logic insert;
      logic drop;
      logic dec;
   } cell_ctl_type;

endpackage

// ----- src/rmrq_cell.sv -----
module rmrq_cell (
   input  logic                 clock,
   input  rmrq_pkg::cell_ctl_type ctl,
   input  rmrq_pkg::slot_type   new_slot,
   input  rmrq_pkg::slot_type   prev_slot,
   input  rmrq_pkg::slot_type   next_slot,
   input  logic                 prev_occ,
   input  logic                 prev_gt,
   input  logic                 occ,
   output rmrq_pkg::slot_type   slot,
   output logic                 gt
);
   import rmrq_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;
   logic     take_new;
   logic     take_prev;

   // this slot holds a job of longer period than the one being released
   assign gt = occ && (slot_ff.period > new_slot.period);

   assign take_new  = ctl.insert && (!occ || gt) && prev_occ && !prev_gt;
   assign take_prev = ctl.insert && prev_occ && prev_gt;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.drop) begin
         slot_in = next_slot;
      end else if (take_prev) begin
         slot_in = prev_slot;
      end else if (take_new) begin
         slot_in = new_slot;
      end else if (ctl.dec && (slot_ff.remaining != 16'd0)) begin
         slot_in.remaining = slot_ff.remaining - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

// ----- src/rate_monotonic_ready_queue_core.sv -----
// latency: a result beat is registered and becomes valid in the cycle after its request beat is accepted
// throughput: one item per cycle while rsp_ready stays high; the sorted insert is a
//   single parallel period compare across the row of slot cells
// reset: synchronous, clears count, time, job tags and the result valid flag;
//   slot contents and the result payload are left as they are and only slots below the count are read
`include "rate_monotonic_ready_queue_core_assert.svh"

module rate_monotonic_ready_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_task_number,
   input  logic [15:0] req_job_period,
   input  logic [15:0] req_job_cost,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_running_task,
   output logic [7:0]  rsp_preempted_task,
   output logic        rsp_job_started,
   output logic        rsp_job_completed,
   output logic        rsp_deadline_missed,
   output logic [31:0] rsp_current_time
);
   import rmrq_pkg::*;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      time_ff, time_in;
   logic [15:0]      last_tag_ff, last_tag_in;
   logic             last_valid_ff, last_valid_in;
   logic [15:0]      next_tag_ff, next_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // result register
   logic [2:0]  status_ff, status_in;
   logic [7:0]  running_ff, running_in;
   logic [7:0]  preempted_ff, preempted_in;
   logic        started_ff, started_in;
   logic        completed_ff, completed_in;
   logic        missed_ff, missed_in;

   // row of cells
   slot_type     slots [QUEUE_DEPTH];
   logic         gts   [QUEUE_DEPTH];
   logic         occs  [QUEUE_DEPTH];
   cell_ctl_type ctls  [QUEUE_DEPTH];
   slot_type     new_slot;
   slot_type     head;

   logic        accept;
   logic        do_insert;
   logic        do_drop;
   logic        do_dec;
   logic [15:0] head_rem_next;
   logic [32:0] deadline;

   // the result register frees up whenever its beat is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign head = slots[0];

   // job stamped with the current time and the next tag
   always_comb begin
      new_slot.period       = req_job_period;
      new_slot.cost         = req_job_cost;
      new_slot.remaining    = req_job_cost;
      new_slot.task_id      = req_task_number;
      new_slot.release_time = time_ff;
      new_slot.tag          = next_tag_ff;
   end

   assign head_rem_next = (head.remaining != 16'd0) ? (head.remaining - 16'd1) : 16'd0;

   always_comb begin
      count_in      = count_ff;
      time_in       = time_ff;
      last_tag_in   = last_tag_ff;
      last_valid_in = last_valid_ff;
      next_tag_in   = next_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      running_in    = running_ff;
      preempted_in  = preempted_ff;
      started_in    = started_ff;
      completed_in  = completed_ff;
      missed_in     = missed_ff;
      do_insert     = 1'b0;
      do_drop       = 1'b0;
      do_dec        = 1'b0;
      deadline      = {1'b0, head.release_time} + {17'd0, head.period};

      if (accept) begin
         rsp_valid_in = 1'b1;
         preempted_in = 8'd0;
         started_in   = 1'b0;
         completed_in = 1'b0;
         missed_in    = 1'b0;
         if (req_command == CMD_RELEASE) begin
            running_in = req_task_number;
            if (req_job_cost == 16'd0) begin
               status_in = ST_REJECTED;
            end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               do_insert   = 1'b1;
               count_in    = count_ff + 1'b1;
               next_tag_in = next_tag_ff + 16'd1;
               status_in   = ST_QUEUED;
               // new job lands in front of a head that has already run
               if (gts[0] && (head.remaining != head.cost)) begin
                  status_in    = ST_PREEMPT;
                  preempted_in = head.task_id;
               end
            end
         end else begin
            if (time_ff != 32'hFFFF_FFFF) begin
               time_in = time_ff + 32'd1;
            end
            if (count_ff == '0) begin
               status_in  = ST_IDLE;
               running_in = 8'd0;
            end else begin
               status_in     = ST_RAN;
               running_in    = head.task_id;
               started_in    = (head.remaining == head.cost) ||
                               (last_valid_ff && (head.tag != last_tag_ff));
               last_tag_in   = head.tag;
               last_valid_in = 1'b1;
               if (head_rem_next == 16'd0) begin
                  // job done: deadline check against the advanced time, no wrap
                  do_drop  = 1'b1;
                  count_in = count_ff - 1'b1;
                  if (deadline >= {1'b0, time_in}) begin
                     completed_in = 1'b1;
                  end else begin
                     missed_in = 1'b1;
                  end
               end else begin
                  do_dec = 1'b1;
               end
            end
         end
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         assign occs[gi] = (count_ff > CNT_W'(gi));

         always_comb begin
            ctls[gi].insert = do_insert;
            ctls[gi].drop   = do_drop;
            ctls[gi].dec    = (gi == 0) ? do_dec : 1'b0;
         end

         if (gi == 0) begin : g_head
            // head compares as if behind an occupied, shorter-period slot
            rmrq_cell u_cell (
               .clock     (clock),
               .ctl       (ctls[gi]),
               .new_slot  (new_slot),
               .prev_slot (new_slot),
               .next_slot (slots[gi+1]),
               .prev_occ  (1'b1),
               .prev_gt   (1'b0),
               .occ       (occs[gi]),
               .slot      (slots[gi]),
               .gt        (gts[gi])
            );
         end else if (gi == QUEUE_DEPTH - 1) begin : g_tail
            // tail takes nothing from behind; its slot is empty after a drop
            rmrq_cell u_cell (
               .clock     (clock),
               .ctl       (ctls[gi]),
               .new_slot  (new_slot),
               .prev_slot (slots[gi-1]),
               .next_slot (slots[gi]),
               .prev_occ  (occs[gi-1]),
               .prev_gt   (gts[gi-1]),
               .occ       (occs[gi]),
               .slot      (slots[gi]),
               .gt        (gts[gi])
            );
         end else begin : g_mid
            rmrq_cell u_cell (
               .clock     (clock),
               .ctl       (ctls[gi]),
               .new_slot  (new_slot),
               .prev_slot (slots[gi-1]),
               .next_slot (slots[gi+1]),
               .prev_occ  (occs[gi-1]),
               .prev_gt   (gts[gi-1]),
               .occ       (occs[gi]),
               .slot      (slots[gi]),
               .gt        (gts[gi])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         time_ff       <= '0;
         last_tag_ff   <= '0;
         last_valid_ff <= 1'b0;
         next_tag_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         time_ff       <= time_in;
         last_tag_ff   <= last_tag_in;
         last_valid_ff <= last_valid_in;
         next_tag_ff   <= next_tag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, held while the beat is stalled
   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      running_ff   <= running_in;
      preempted_ff <= preempted_in;
      started_ff   <= started_in;
      completed_ff <= completed_in;
      missed_ff    <= missed_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_running_task    = running_ff;
   assign rsp_preempted_task  = preempted_ff;
   assign rsp_job_started     = started_ff;
   assign rsp_job_completed   = completed_ff;
   assign rsp_deadline_missed = missed_ff;
   assign rsp_current_time    = time_ff;

   // queue never holds more jobs than it has cells
   `RMRQ_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   // jobs leave the queue only on an accepted tick
   `RMRQ_ASSERT(a_drop_on_tick, clock, reset, (!$past(reset) && (count_ff < $past(count_ff))) |-> $past(accept && (req_command == CMD_TICK)), "job removed without a tick")
   // time counter never steps back outside reset
   `RMRQ_ASSERT(a_time_mono, clock, reset, !$past(reset) |-> (time_ff >= $past(time_ff)), "time counter went backwards")
   // a new result beat appears only after an accepted request
   `RMRQ_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid_ff) |-> $past(accept), "result beat without request")

endmodule
